### design/jdsg_pkg.sv
package jdsg_pkg;

  // Field and register widths.
  localparam int RAW_W   = 16;
  localparam int CFG_W   = 15;
  localparam int PCT_W   = 7;
  localparam int SLEW_W  = 11;
  localparam int CMD_W   = 11;

  // Serial divider geometry: the dividend is |deadbanded axis| * 1000,
  // which stays below 2^25, and two quotient bits are produced per cycle.
  localparam int DIVD_W  = 26;
  localparam int DIVS_W  = 15;
  localparam int DIV_STEPS = DIVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Command scaling constants.
  localparam int CMD_MAX  = 1000;
  localparam int PROD_W   = 33;
  // Products at or above this value divide by 100 to more than CMD_MAX.
  localparam int CLAMP_P  = 100100;
  localparam int RECIP_IN_W = 17;
  // floor(p * RECIP_K / 2^RECIP_SH) equals floor(p / 100) for p < CLAMP_P.
  localparam int RECIP_K  = 167773;
  localparam int RECIP_KW = 18;
  localparam int RECIP_SH = 24;

  typedef enum logic [1:0] {
    CFG_DEADBAND   = 2'd0,
    CFG_FULL_SCALE = 2'd1,
    CFG_SPEED      = 2'd2,
    CFG_SLEW       = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_PCT,
    S_RECIP,
    S_SLEW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/jdsg_in_if.sv
interface jdsg_in_if;
  logic               valid;
  logic               ready;
  logic               reading_valid;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic               dm_switch;

  modport source (output valid, output reading_valid, output raw_x, output raw_y,
                  output dm_switch, input ready);
  modport sink (input valid, input reading_valid, input raw_x, input raw_y,
                input dm_switch, output ready);
endinterface

### design/jdsg_out_if.sv
interface jdsg_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] command_x;
  logic signed [10:0] command_y;
  logic               motion_ok;
  logic               dm_engaged;
  logic               waiting_for_neutral;

  modport source (output valid, output command_x, output command_y,
                  output motion_ok, output dm_engaged,
                  output waiting_for_neutral, input ready);
  modport sink (input valid, input command_x, input command_y,
                input motion_ok, input dm_engaged,
                input waiting_for_neutral, output ready);
endinterface

### design/jdsg_div.sv
module jdsg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [jdsg_pkg::DIVD_W-1:0] dividend,
  input  logic [jdsg_pkg::DIVS_W-1:0] divisor,
  output logic [jdsg_pkg::DIVD_W-1:0] quot,
  output jdsg_pkg::div_stat_t         stat
);
  import jdsg_pkg::*;

  // Restoring radix-4 divider: the dividend shifts out of the top of dq_r
  // two bits a cycle while quotient bits shift in at the bottom.
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r;
  logic [DIVD_W-1:0]    dq_r, dq_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVS_W:0]   t1, t2, d_ext;
  logic [DIVS_W-1:0] r1;
  logic              ge1, ge2;

  always_comb begin
    d_ext   = {1'b0, dvs_r};
    t1      = {rem_r, dq_r[DIVD_W-1]};
    ge1     = (t1 >= d_ext);
    r1      = ge1 ? DIVS_W'(t1 - d_ext) : DIVS_W'(t1);
    t2      = {r1, dq_r[DIVD_W-2]};
    ge2     = (t2 >= d_ext);
    rem_nxt = ge2 ? DIVS_W'(t2 - d_ext) : DIVS_W'(t2);
    dq_nxt  = {dq_r[DIVD_W-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign quot      = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### design/joystick_deadband_slew_gate_unit.sv
// Joystick gate: each input beat is one joystick tick and yields exactly one
// output beat. A live tick (valid reading, neutral confirmed, dead-man held)
// runs each axis in turn through the shared serial divider, which produces
// two quotient bits a cycle and runs 13 steps, then through the percent
// product, the reciprocal divide by 100 and the slew step, and its result is
// then loaded into the output register; every other tick goes straight to
// the load. The next beat can be taken only after the result is loaded, and
// a stalled output register holds the sequencer until the register frees. A
// new tick is accepted whenever the sequencer is idle, even while the
// previous result still waits in the output register.
module joystick_deadband_slew_gate_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  jdsg_in_if.sink                    in_chan,
  jdsg_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  jdsg_pkg::cfg_idx_t         cfg_index,
  input  logic [jdsg_pkg::CFG_W-1:0] cfg_wdata
);
  import jdsg_pkg::*;

  // Returns 1 when a raw reading lies inside the neutral zone.
  function automatic logic in_deadband(input logic signed [RAW_W-1:0] raw,
                                       input logic [CFG_W-1:0] db);
    logic signed [RAW_W:0] r;
    logic signed [RAW_W:0] d;
    r = {raw[RAW_W-1], raw};
    d = {2'b00, db};
    return (r <= d) && (r >= -d);
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]  db_r;
  logic [CFG_W-1:0]  fs_r;
  logic [PCT_W-1:0]  pct_r;
  logic [SLEW_W-1:0] slew_r;

  // Sequencer and the latched tick.
  state_t                   state_r, state_nxt;
  logic                     axis_r;
  logic                     vld_r;
  logic signed [RAW_W-1:0]  rx_r, ry_r;
  logic                     dm_r;

  // Persistent state.
  logic                     neutral_r, neutral_nxt;
  logic signed [CMD_W-1:0]  held_x_r, held_x_nxt;
  logic signed [CMD_W-1:0]  held_y_r, held_y_nxt;

  // Per-axis working registers.
  logic                     neg_r;
  logic [PROD_W-1:0]        prod_r;
  logic [CMD_W-1:0]         mag_r;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CMD_W-1:0]  cmd_x_r, cmd_y_r;
  logic                     allowed_r, engaged_r, waiting_r;

  // Control decodes.
  logic live;
  logic accept;
  logic out_free;
  logic div_start;
  logic fin_load;
  div_stat_t div_stat;

  assign live     = vld_r && neutral_r && dm_r;
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign fin_load = (state_r == S_FIN) && out_free;

  // The deadband stage works on whichever axis is in progress. The
  // magnitude of the deadbanded value never exceeds 32768.
  logic signed [RAW_W-1:0] raw_sel;
  logic signed [RAW_W:0]   raw_e, db_e, mag_full;
  logic                    above, below;
  logic [RAW_W-1:0]        mag;
  logic [DIVD_W-1:0]       dividend;
  logic [CFG_W:0]          span_diff;
  logic [DIVS_W-1:0]       span;
  logic [DIVD_W-1:0]       quot;

  always_comb begin
    raw_sel   = axis_r ? ry_r : rx_r;
    raw_e     = {raw_sel[RAW_W-1], raw_sel};
    db_e      = {2'b00, db_r};
    above     = raw_e > db_e;
    below     = raw_e < -db_e;
    if (above) begin
      mag_full = raw_e - db_e;
    end else if (below) begin
      mag_full = -raw_e - db_e;
    end else begin
      mag_full = '0;
    end
    mag       = mag_full[RAW_W-1:0];
    dividend  = {{(DIVD_W-RAW_W){1'b0}}, mag} * DIVD_W'(CMD_MAX);
    // A full scale at or below the deadband divides by one.
    span_diff = {1'b0, fs_r} - {1'b0, db_r};
    span      = (fs_r > db_r) ? span_diff[DIVS_W-1:0] : DIVS_W'(1);
  end

  jdsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .quot     (quot),
    .stat     (div_stat)
  );

  // Percent scaling: the quotient times the percent, then divided by 100
  // through a reciprocal multiply. Large products saturate at full command.
  logic [RECIP_IN_W+RECIP_KW-1:0] rprod;
  logic [CMD_W-1:0]               mag_nxt;

  always_comb begin
    rprod   = prod_r[RECIP_IN_W-1:0] * RECIP_KW'(RECIP_K);
    mag_nxt = (prod_r >= PROD_W'(CLAMP_P)) ? CMD_W'(CMD_MAX)
                                           : rprod[RECIP_SH +: CMD_W];
  end

  // Slew limiter: move the held value toward the target by at most the
  // configured step. Twelve bits cover every difference of two commands.
  logic signed [CMD_W:0]   target, held_e, diff, step, lim, newv;
  logic signed [CMD_W-1:0] held_sel;

  always_comb begin
    held_sel = axis_r ? held_y_r : held_x_r;
    held_e   = {held_sel[CMD_W-1], held_sel};
    target   = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    diff     = target - held_e;
    step     = $signed({1'b0, slew_r});
    if (diff > step) begin
      lim = step;
    end else if (diff < -step) begin
      lim = -step;
    end else begin
      lim = diff;
    end
    newv     = held_e + lim;
  end

  // Held values and the neutral flag. Non-live ticks clear the held values
  // when their result is loaded; live ticks update them in the slew cycle.
  always_comb begin
    held_x_nxt  = held_x_r;
    held_y_nxt  = held_y_r;
    neutral_nxt = neutral_r;
    if (state_r == S_SLEW) begin
      if (axis_r) begin
        held_y_nxt = newv[CMD_W-1:0];
      end else begin
        held_x_nxt = newv[CMD_W-1:0];
      end
    end
    if (fin_load) begin
      if (!live) begin
        held_x_nxt = '0;
        held_y_nxt = '0;
      end
      if (vld_r && !neutral_r && in_deadband(rx_r, db_r) && in_deadband(ry_r, db_r)) begin
        neutral_nxt = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_chan.valid) state_nxt = S_PREP;
      S_PREP:  state_nxt = live ? S_DIV : S_FIN;
      S_DIV:   if (div_stat.done) state_nxt = S_PCT;
      S_PCT:   state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_SLEW;
      S_SLEW:  state_nxt = axis_r ? S_FIN : S_PREP;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State-decoded controls.
  always_comb begin
    in_chan.ready = (state_r == S_IDLE);
    div_start     = (state_r == S_PREP) && live;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      neutral_r   <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      out_valid_r <= 1'b0;
      db_r        <= CFG_W'(50);
      fs_r        <= CFG_W'(2047);
      pct_r       <= PCT_W'(100);
      slew_r      <= SLEW_W'(50);
    end else begin
      state_r     <= state_nxt;
      neutral_r   <= neutral_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        axis_r <= 1'b0;
      end else if (state_r == S_SLEW) begin
        axis_r <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEADBAND:   db_r   <= cfg_wdata;
          CFG_FULL_SCALE: fs_r   <= cfg_wdata;
          CFG_SPEED:      pct_r  <= cfg_wdata[PCT_W-1:0];
          CFG_SLEW:       slew_r <= cfg_wdata[SLEW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      vld_r <= in_chan.reading_valid;
      rx_r  <= in_chan.raw_x;
      ry_r  <= in_chan.raw_y;
      dm_r  <= in_chan.dm_switch;
    end
    if (state_r == S_PREP) begin
      neg_r <= below;
    end
    if (state_r == S_PCT) begin
      prod_r <= PROD_W'(quot) * PROD_W'(pct_r);
    end
    if (state_r == S_RECIP) begin
      mag_r <= mag_nxt;
    end
    if (fin_load) begin
      cmd_x_r   <= live ? held_x_r : '0;
      cmd_y_r   <= live ? held_y_r : '0;
      allowed_r <= live;
      // Valid ticks before neutral is confirmed echo the switch; live ticks report it engaged.
      engaged_r <= live || (vld_r && !neutral_r && dm_r);
      waiting_r <= !neutral_nxt;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.command_x           = cmd_x_r;
  assign out_chan.command_y           = cmd_y_r;
  assign out_chan.motion_ok           = allowed_r;
  assign out_chan.dm_engaged          = engaged_r;
  assign out_chan.waiting_for_neutral = waiting_r;

endmodule

### design/jdsg_chk.sv
module jdsg_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [10:0] command_x,
  input logic signed [10:0] command_y,
  input logic               motion_ok,
  input logic               dm_engaged,
  input logic               waiting_for_neutral
);

  // A stalled result beat keeps its commands and its motion flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(command_x) && $stable(command_y)
      && $stable(motion_ok))
    else $error("result beat changed while stalled");

  // Live commands only with the switch engaged and neutral confirmed.
  a_live_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && motion_ok |-> dm_engaged && !waiting_for_neutral)
    else $error("live beat with inconsistent flags");

  // While waiting for neutral nothing moves.
  a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && waiting_for_neutral |->
      !motion_ok && command_x == 11'sd0 && command_y == 11'sd0)
    else $error("movement while waiting for neutral");

  // Commands are bounded and zero whenever movement is not allowed.
  a_cmd_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (motion_ok || (command_x == 11'sd0 && command_y == 11'sd0))
      && command_x <= 11'sd1000 && command_x >= -11'sd1000
      && command_y <= 11'sd1000 && command_y >= -11'sd1000)
    else $error("command out of range or not gated");

endmodule

bind joystick_deadband_slew_gate_unit jdsg_chk u_jdsg_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .command_x           (out_chan.command_x),
  .command_y           (out_chan.command_y),
  .motion_ok           (out_chan.motion_ok),
  .dm_engaged          (out_chan.dm_engaged),
  .waiting_for_neutral (out_chan.waiting_for_neutral)
);

### bench/joystick_command_monitor.sv
`timescale 1ns / 100ps

// Watches both channels of the joystick gate and the register port, predicts
// every result beat from the accepted ticks, and compares in order.
module joystick_command_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  jdsg_in_if                         in_mon,
  jdsg_out_if                        out_mon,
  input  logic                       cfg_we,
  input  jdsg_pkg::cfg_idx_t         cfg_index,
  input  logic [jdsg_pkg::CFG_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending_results
);
  import jdsg_pkg::*;

  localparam int PERCENT_DIV = 100;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd_x;
    logic signed [CMD_W-1:0] cmd_y;
    logic                    allowed;
    logic                    engaged;
    logic                    waiting;
  } tick_result_t;

  // Shadow copies of the registers and of the gate's state.
  logic [CFG_W-1:0]        deadband;
  logic [CFG_W-1:0]        fs_counts;
  logic [PCT_W-1:0]        speed_pct;
  logic [SLEW_W-1:0]       slew_step;
  logic signed [CMD_W-1:0] held_x;
  logic signed [CMD_W-1:0] held_y;
  logic                    neutral_ok;

  tick_result_t command_q[$];
  int           result_index;

  function automatic longint trim_deadband(input logic signed [RAW_W-1:0] raw);
    longint v;
    longint db;
    v  = raw;
    db = longint'(deadband);
    if (v > db) return v - db;
    if (v < -db) return v + db;
    return 0;
  endfunction

  function automatic longint axis_to_command(input logic signed [RAW_W-1:0] raw);
    longint span;
    longint s;
    span = longint'(fs_counts) - longint'(deadband);
    if (span <= 0) span = 1;
    s = (trim_deadband(raw) * CMD_MAX) / span;
    s = (s * longint'(speed_pct)) / PERCENT_DIV;
    if (s < -CMD_MAX) s = -CMD_MAX;
    if (s > CMD_MAX) s = CMD_MAX;
    return s;
  endfunction

  function automatic logic signed [CMD_W-1:0] slew_toward(
      input logic signed [CMD_W-1:0] last, input longint target);
    longint d;
    longint lim;
    longint sum;
    lim = longint'(slew_step);
    d   = target - longint'(last);
    if (d > lim) d = lim;
    else if (d < -lim) d = -lim;
    sum = longint'(last) + d;
    return sum[CMD_W-1:0];
  endfunction

  // Advances the shadow state by one tick and returns the result it yields.
  function automatic tick_result_t predict_command(input logic rv,
      input logic signed [RAW_W-1:0] rx, input logic signed [RAW_W-1:0] ry,
      input logic dm);
    tick_result_t r;
    r = '0;
    if (!rv) begin
      held_x    = '0;
      held_y    = '0;
      r.waiting = !neutral_ok;
    end else if (!neutral_ok) begin
      if (trim_deadband(rx) == 0 && trim_deadband(ry) == 0) neutral_ok = 1'b1;
      held_x    = '0;
      held_y    = '0;
      r.waiting = !neutral_ok;
      r.engaged = dm;
    end else if (!dm) begin
      held_x = '0;
      held_y = '0;
    end else begin
      held_x    = slew_toward(held_x, axis_to_command(rx));
      held_y    = slew_toward(held_y, axis_to_command(ry));
      r.cmd_x   = held_x;
      r.cmd_y   = held_y;
      r.allowed = 1'b1;
      r.engaged = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      deadband     = 15'd50;
      fs_counts    = 15'd2047;
      speed_pct    = 7'd100;
      slew_step    = 11'd50;
      held_x       = '0;
      held_y       = '0;
      neutral_ok   = 1'b0;
      result_index = 0;
      fail_count   = 0;
      command_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (command_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat %0d arrived with nothing predicted", $time,
                     result_index);
        end else begin
          want = command_q.pop_front();
          if (out_mon.command_x !== want.cmd_x || out_mon.command_y !== want.cmd_y ||
              out_mon.motion_ok !== want.allowed ||
              out_mon.dm_engaged !== want.engaged ||
              out_mon.waiting_for_neutral !== want.waiting) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result beat %0d: expected x=%0d y=%0d allowed=%0b",
                       $time, result_index, want.cmd_x, want.cmd_y, want.allowed,
                       " engaged=%0b waiting=%0b, got x=%0d y=%0d", want.engaged,
                       want.waiting, out_mon.command_x, out_mon.command_y,
                       " allowed=%0b engaged=%0b waiting=%0b", out_mon.motion_ok,
                       out_mon.dm_engaged, out_mon.waiting_for_neutral);
          end
        end
        result_index++;
      end
      if (in_mon.valid && in_mon.ready)
        command_q.push_back(predict_command(in_mon.reading_valid, in_mon.raw_x,
                                            in_mon.raw_y, in_mon.dm_switch));
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEADBAND:   deadband   = cfg_wdata;
          CFG_FULL_SCALE: fs_counts  = cfg_wdata;
          CFG_SPEED:      speed_pct  = cfg_wdata[PCT_W-1:0];
          CFG_SLEW:       slew_step  = cfg_wdata[SLEW_W-1:0];
          default: begin
          end
        endcase
      end
    end
    pending_results = command_q.size();
  end

endmodule

### bench/tb_joystick_deadband_slew_gate_unit.sv
`timescale 1ns / 100ps

// Top of the joystick gate bench. It only makes stimulus and gives the
// verdict; the monitor beside the block predicts and compares every beat.
module tb_joystick_deadband_slew_gate_unit;
  import jdsg_pkg::*;

  // Enough quiet cycles after the last result for a live tick to pass through
  // the block, so that anything stray has time to show up.
  localparam int DRAIN_CYCLES = 48;
  // The longest stretch in which the receiver holds off on purpose.
  localparam int LONG_HOLD    = 400;
  // Cycles without any accepted beat before the run is declared hung. The
  // slowest legitimate gap is the long hold plus one live tick and a burst.
  localparam int QUIET_LIMIT  = 4000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_t           cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  int                 fail_count;
  int                 pending_results;

  // Stimulus knobs shared by the sender, the receiver and the sequence. The
  // receiver serves the long hold once, the first time it sees the request.
  logic               source_gaps;
  logic               sink_stalls;
  logic               hold_req;
  int                 cur_db;
  int                 cur_fs;

  jdsg_in_if  in_chan();
  jdsg_out_if out_chan();

  joystick_deadband_slew_gate_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  joystick_command_monitor command_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Offers one tick and returns at the falling edge after its beat has been
  // taken. The valid line stays high on return, so back-to-back ticks never
  // lower and raise it within one step; a gap lowers it on its own step.
  task automatic send_tick(input logic rv, input logic signed [RAW_W-1:0] rx,
                           input logic signed [RAW_W-1:0] ry, input logic dm);
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.reading_valid <= rv;
    in_chan.raw_x         <= rx;
    in_chan.raw_y         <= ry;
    in_chan.dm_switch     <= dm;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted result has come back, so
  // the block is idle and the registers may be rewritten.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Writes all four registers on consecutive edges. The write enable stays
  // high across them and drops only after the last one.
  task automatic program_regs(input int db, input int fs, input int pct,
                              input int slew);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEADBAND;
    cfg_wdata <= db[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_FULL_SCALE;
    cfg_wdata <= fs[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_SPEED;
    cfg_wdata <= pct[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_SLEW;
    cfg_wdata <= slew[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_db = db;
    cur_fs = fs;
  endtask

  // Picks one raw axis value. Half land in the working range of the current
  // setting so that commands ramp through the slew limiter; the rest hit the
  // deadband edges, the extremes of the field, or anything at all.
  function automatic logic signed [RAW_W-1:0] pick_axis();
    int mag;
    int reach;
    logic [31:0] any;
    case ($urandom_range(0, 9))
      0, 1: begin
        any = $urandom;
        return any[RAW_W-1:0];
      end
      2, 3: begin
        mag = cur_db - 1 + int'($urandom_range(0, 3));
        if (mag < 0) mag = 0;
        if (mag > 32767) mag = 32767;
        return RAW_W'($urandom_range(0, 1) ? -mag : mag);
      end
      4: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: begin
        reach = cur_db + cur_fs + 64;
        if (reach > 32767) reach = 32767;
        return RAW_W'(int'($urandom_range(0, 2 * reach)) - reach);
      end
    endcase
  endfunction

  // Mostly valid ticks with the dead-man held, so the held commands keep
  // chasing their targets; now and then an invalid tick or a release.
  task automatic send_random_tick();
    logic rv;
    logic dm;
    rv = ($urandom_range(0, 11) != 0);
    dm = ($urandom_range(0, 7) != 0);
    send_tick(rv, pick_axis(), pick_axis(), dm);
  endtask

  task automatic run_phase(input int db, input int fs, input int pct, input int slew,
                           input int count);
    settle();
    program_regs(db, fs, pct, slew);
    repeat (count) send_random_tick();
  endtask

  // Receiver: random stall bursts while stalls are enabled, plus one long
  // hold on request, counted here so that the sender keeps pushing meanwhile.
  initial begin : result_sink
    logic hold_done;
    hold_done      = 1'b0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  // Ends a hung run: any beat on either channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int db;
    int fs;
    int slew;
    in_chan.valid         = 1'b0;
    in_chan.reading_valid = 1'b0;
    in_chan.raw_x         = '0;
    in_chan.raw_y         = '0;
    in_chan.dm_switch     = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_DEADBAND;
    cfg_wdata             = '0;
    rst_n                 = 1'b0;
    source_gaps           = 1'b0;
    sink_stalls           = 1'b0;
    hold_req              = 1'b0;
    cur_db                = 50;
    cur_fs                = 2047;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    source_gaps = 1'b1;
    sink_stalls = 1'b1;

    // Directed ticks at the reset settings. First the wait for neutral:
    // invalid ticks, off-center ticks with and without the dead-man, and
    // axes one count outside the deadband, all of which must keep waiting.
    send_tick(1'b0, 16'sh7fff, 16'sh8000, 1'b1);
    send_tick(1'b1, 16'sh7fff, 16'sd0, 1'b1);
    send_tick(1'b1, 16'sd0, -16'sd51, 1'b0);
    send_tick(1'b1, 16'sd51, 16'sd50, 1'b1);
    send_tick(1'b0, 16'sd0, 16'sd0, 1'b0);
    // Both axes right on the deadband edge confirm neutral; still no motion.
    send_tick(1'b1, -16'sd50, 16'sd50, 1'b0);
    // Live ticks at full deflection ramp by the slew step.
    send_tick(1'b1, 16'sh7fff, 16'sh8000, 1'b1);
    send_tick(1'b1, 16'sh7fff, 16'sh8000, 1'b1);
    // Releasing the dead-man drops both commands at once.
    send_tick(1'b1, 16'sd2047, -16'sd2047, 1'b0);
    send_tick(1'b1, 16'sd2047, -16'sd2047, 1'b1);
    send_tick(1'b1, 16'sd2047, -16'sd2047, 1'b1);
    // An invalid tick after confirmation zeroes the held commands.
    send_tick(1'b0, 16'sd2047, -16'sd2047, 1'b1);
    send_tick(1'b1, 16'sh8000, 16'sh7fff, 1'b1);
    send_tick(1'b1, -16'sd1, 16'sd0, 1'b1);
    send_tick(1'b1, 16'sd1048, -16'sd1048, 1'b1);
    send_tick(1'b1, 16'sd60, -16'sd60, 1'b1);
    send_tick(1'b1, 16'sd0, 16'sd0, 1'b1);

    // Random phases across the register space, the reset settings first, then
    // extremes: the widest span with an instant slew, a deadband that swallows
    // all but -32768 with zero speed and zero slew, and a divisor forced to one.
    run_phase(50, 2047, 100, 50, 250);
    run_phase(0, 32767, 100, 2000, 200);
    run_phase(32767, 0, 0, 0, 100);
    run_phase(0, 0, 100, 2000, 150);

    // Here the receiver holds off for a long time while ticks keep coming,
    // so the output register fills and the input backs up.
    settle();
    program_regs(100, 1000, 37, 17);
    hold_req = 1'b1;
    repeat (200) send_random_tick();

    // With zero slew the held commands never move toward their targets.
    run_phase(5, 300, 100, 0, 100);
    run_phase(20, 500, 1, 2000, 150);
    repeat (2) begin
      db   = $urandom_range(0, 300);
      fs   = $urandom_range(0, 3000);
      slew = $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 2000);
      run_phase(db, fs, $urandom_range(0, 100), slew, 150);
    end

    // The last stretch runs at full rate with no idling on either side.
    settle();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    db   = $urandom_range(0, 200);
    fs   = $urandom_range(500, 2500);
    slew = $urandom_range(1, 120);
    run_phase(db, fs, $urandom_range(50, 100), slew, 300);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
design/jdsg_pkg.sv
design/jdsg_in_if.sv
design/jdsg_out_if.sv
design/jdsg_div.sv
design/joystick_deadband_slew_gate_unit.sv
design/jdsg_chk.sv
bench/joystick_command_monitor.sv
bench/tb_joystick_deadband_slew_gate_unit.sv
